FILE: hdl/assert_macros.svh
// Assertion macros for the checker file of this project.
// Stand-alone header with no dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that is also checked while reset is high.
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/lrt_pkg.sv
// Package of the LRU recency tracker: request codes, cell control and register map.
// No dependencies.
`default_nettype none

package lrt_pkg;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_TOUCH  = 2'd1,
    REQ_REMOVE = 2'd2
  } lrt_req_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_FRONT,
    CELL_INSERT,
    CELL_DROP
  } lrt_mode_t;

  typedef struct packed {
    lrt_mode_t mode;
    logic      evict;
  } lrt_cell_ctl_t;

  localparam int unsigned CAP_BITS     = 5;
  localparam int unsigned OCC_BITS     = 5;
  localparam int unsigned FIELD_ID_W   = 8;
  localparam int unsigned DATA_W       = 32;
  localparam int unsigned ADDR_W       = 3;

  localparam logic [ADDR_W-1:0]   REG_CAPACITY   = 3'd0;
  localparam logic [CAP_BITS-1:0] CAPACITY_RESET = 5'd16;

endpackage

`default_nettype wire

FILE: hdl/lrt_cell.sv
// One position of the recency order: holds one id and shifts it with its neighbors.
// Depends on lrt_pkg.
`default_nettype none

module lrt_cell #(
  parameter int unsigned IDX     = 0,
  parameter int unsigned ID_BITS = 8,
  parameter int unsigned CNT_W   = 5
) (
  input  wire                         clk,
  input  lrt_pkg::lrt_cell_ctl_t      ctl,
  input  wire         [CNT_W-1:0]     held_count,
  input  wire         [ID_BITS-1:0]   req_id,
  input  wire         [ID_BITS-1:0]   left_id,
  input  wire         [ID_BITS-1:0]   right_id,
  input  wire                         hit_before_in,
  input  wire                         hit_after_in,
  input  wire         [ID_BITS-1:0]   tail_in,
  output logic        [ID_BITS-1:0]   stored,
  output logic                        hit_before_out,
  output logic                        hit_after_out,
  output logic        [ID_BITS-1:0]   tail_out
);

  localparam bit FIRST = (IDX == 0);

  logic               valid;
  logic               is_last;
  logic               hit;
  logic               take_new;
  logic [ID_BITS-1:0] shift_val;
  logic [ID_BITS-1:0] stored_next;

  assign valid          = CNT_W'(IDX) < held_count;
  assign is_last        = CNT_W'(IDX + 1) == held_count;
  assign hit            = valid && (stored == req_id);
  assign hit_before_out = hit_before_in | hit;
  assign hit_after_out  = hit_after_in | hit;
  assign tail_out       = is_last ? stored : tail_in;
  assign shift_val      = FIRST ? req_id : left_id;
  assign take_new       = ctl.evict ? valid : (valid || CNT_W'(IDX) == held_count);

  always_comb begin
    stored_next = stored;
    case (ctl.mode)
      lrt_pkg::CELL_FRONT: begin
        if (hit_after_out) begin
          stored_next = shift_val;
        end
      end
      lrt_pkg::CELL_INSERT: begin
        if (take_new) begin
          stored_next = shift_val;
        end
      end
      lrt_pkg::CELL_DROP: begin
        if (hit_before_out && CNT_W'(IDX + 1) < held_count) begin
          stored_next = right_id;
        end
      end
      default: stored_next = stored;
    endcase
  end

  always_ff @(posedge clk) begin
    stored <= stored_next;
  end

endmodule

`default_nettype wire

FILE: hdl/lru_recency_tracker_unit.sv
// Top level of the LRU recency tracker: request decode, held count, result register.
// Depends on lrt_pkg and lrt_cell.
//
//   channel   signals                                       direction
//   req       req_valid, req_ready, req_type, entry_id      in
//   rsp       rsp_valid, rsp_ready, evicted, evicted_id,
//             present, occupancy                             out
//   cfg       psel, penable, pwrite, paddr, pwdata, prdata   in/out
//
// One request per cycle unless rsp stalls: the whole cell row compares and shifts
// in the cycle of acceptance; the result is in the output register in the cycle after.
// A request is taken whenever the output register is empty or being emptied.
// Reset clears the held count and the output valid flag and sets capacity to 16.
`default_nettype none

module lru_recency_tracker_unit #(
  parameter int unsigned MAX_ENTRIES = 16,
  parameter int unsigned ID_BITS     = 8
) (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire                                   req_valid,
  output logic                                  req_ready,
  input  wire  [1:0]                            req_type,
  input  wire  [lrt_pkg::FIELD_ID_W-1:0]        entry_id,
  output logic                                  rsp_valid,
  input  wire                                   rsp_ready,
  output logic                                  evicted,
  output logic [lrt_pkg::FIELD_ID_W-1:0]        evicted_id,
  output logic                                  present,
  output logic [lrt_pkg::OCC_BITS-1:0]          occupancy,
  input  wire                                   psel,
  input  wire                                   penable,
  input  wire                                   pwrite,
  input  wire  [lrt_pkg::ADDR_W-1:0]            paddr,
  input  wire  [lrt_pkg::DATA_W-1:0]            pwdata,
  output logic [lrt_pkg::DATA_W-1:0]            prdata,
  output logic                                  pready
);

  localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned CW    = (CNT_W > lrt_pkg::CAP_BITS) ? CNT_W : lrt_pkg::CAP_BITS;
  localparam int unsigned XW    = (ID_BITS > lrt_pkg::FIELD_ID_W) ? ID_BITS
                                                                  : lrt_pkg::FIELD_ID_W;

  logic [lrt_pkg::CAP_BITS-1:0] capacity;
  logic [CNT_W-1:0]             held_count;
  logic [CNT_W-1:0]             held_count_next;

  logic                         accept;
  logic [XW-1:0]                id_wide;
  logic [ID_BITS-1:0]           req_id;
  logic [CW-1:0]                cap_wide;
  logic [CW-1:0]                eff_cap;
  logic                         full;
  logic                         held;
  logic                         evict;
  lrt_pkg::lrt_cell_ctl_t       ctl;

  logic [ID_BITS-1:0]           ids [MAX_ENTRIES];
  logic                         hit_before [MAX_ENTRIES+1];
  logic                         hit_after  [MAX_ENTRIES+1];
  logic [ID_BITS-1:0]           tail [MAX_ENTRIES+1];
  logic [XW-1:0]                tail_wide;
  logic [CW-1:0]                occ_wide;

  assign pready    = 1'b1;
  assign req_ready = !rsp_valid || rsp_ready;
  assign accept    = req_valid && req_ready;

  assign id_wide = XW'(entry_id);
  assign req_id  = id_wide[ID_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= lrt_pkg::CAPACITY_RESET;
    end else if (psel && penable && pwrite && pready && paddr == lrt_pkg::REG_CAPACITY) begin
      capacity <= pwdata[lrt_pkg::CAP_BITS-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == lrt_pkg::REG_CAPACITY) begin
      prdata = lrt_pkg::DATA_W'(capacity);
    end
  end

  assign cap_wide = CW'(capacity);

  always_comb begin
    eff_cap = cap_wide;
    if (cap_wide == '0) begin
      eff_cap = CW'(1);
    end else if (cap_wide > CW'(MAX_ENTRIES)) begin
      eff_cap = CW'(MAX_ENTRIES);
    end
  end

  assign full  = (CW'(held_count) >= eff_cap) && (held_count != '0);
  assign held  = hit_before[MAX_ENTRIES];
  assign evict = (req_type == lrt_pkg::REQ_INSERT) && !held && full;

  always_comb begin
    ctl.mode  = lrt_pkg::CELL_HOLD;
    ctl.evict = evict;
    if (accept) begin
      unique case (req_type)
        lrt_pkg::REQ_INSERT: ctl.mode = held ? lrt_pkg::CELL_FRONT : lrt_pkg::CELL_INSERT;
        lrt_pkg::REQ_TOUCH:  ctl.mode = held ? lrt_pkg::CELL_FRONT : lrt_pkg::CELL_HOLD;
        lrt_pkg::REQ_REMOVE: ctl.mode = held ? lrt_pkg::CELL_DROP : lrt_pkg::CELL_HOLD;
        default:             ctl.mode = lrt_pkg::CELL_HOLD;
      endcase
    end
  end

  always_comb begin
    held_count_next = held_count;
    case (ctl.mode)
      lrt_pkg::CELL_INSERT: begin
        if (!evict) begin
          held_count_next = held_count + CNT_W'(1);
        end
      end
      lrt_pkg::CELL_DROP: held_count_next = held_count - CNT_W'(1);
      default:            held_count_next = held_count;
    endcase
  end

  assign hit_before[0]           = 1'b0;
  assign hit_after[MAX_ENTRIES]  = 1'b0;
  assign tail[0]                 = '0;

  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    lrt_cell #(
      .IDX     (g),
      .ID_BITS (ID_BITS),
      .CNT_W   (CNT_W)
    ) u_cell (
      .clk            (clk),
      .ctl            (ctl),
      .held_count     (held_count),
      .req_id         (req_id),
      .left_id        (ids[(g == 0) ? 0 : g - 1]),
      .right_id       (ids[(g == MAX_ENTRIES - 1) ? g : g + 1]),
      .hit_before_in  (hit_before[g]),
      .hit_after_in   (hit_after[g+1]),
      .tail_in        (tail[g]),
      .stored         (ids[g]),
      .hit_before_out (hit_before[g+1]),
      .hit_after_out  (hit_after[g]),
      .tail_out       (tail[g+1])
    );
  end

  assign tail_wide = XW'(tail[MAX_ENTRIES]);
  assign occ_wide  = CW'(held_count_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      held_count <= held_count_next;
      if (accept) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      evicted    <= evict;
      evicted_id <= evict ? tail_wide[lrt_pkg::FIELD_ID_W-1:0] : '0;
      present    <= held;
      occupancy  <= occ_wide[lrt_pkg::OCC_BITS-1:0];
    end
  end

endmodule

`default_nettype wire

FILE: hdl/lrt_checker.sv
// Port-level checks of the LRU recency tracker, bound to the top level.
// Depends on lrt_pkg, assert_macros.svh and lru_recency_tracker_unit.
`default_nettype none
`include "assert_macros.svh"

module lrt_checker #(
  parameter int unsigned MAX_ENTRIES = 16
) (
  input wire                              clk,
  input wire                              rst,
  input wire                              rsp_valid,
  input wire                              rsp_ready,
  input wire                              evicted,
  input wire [lrt_pkg::FIELD_ID_W-1:0]    evicted_id,
  input wire                              present,
  input wire [lrt_pkg::OCC_BITS-1:0]      occupancy
);

  `ASSERT_CLK(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready |=> rsp_valid && $stable({evicted, evicted_id, present, occupancy}), "Stalled transaction changed.")
  `ASSERT_CLK(a_no_evict_zero, clk, rst, rsp_valid && !evicted |-> evicted_id == '0, "Evicted id is not zero without an eviction.")
  `ASSERT_CLK(a_evict_new_id, clk, rst, rsp_valid && evicted |-> !present && occupancy != '0, "Eviction reported for a held id or an empty order.")
  `ASSERT_CLK(a_occ_bound, clk, rst, rsp_valid |-> 32'(occupancy) <= 32'(MAX_ENTRIES), "Occupancy exceeds the number of cells.")
  `ASSERT_CLK_ALWAYS(a_reset_idle, clk, $fell(rst) |-> !rsp_valid, "Response valid right after reset.")

endmodule

bind lru_recency_tracker_unit lrt_checker #(
  .MAX_ENTRIES (MAX_ENTRIES)
) u_lrt_checker (
  .clk        (clk),
  .rst        (rst),
  .rsp_valid  (rsp_valid),
  .rsp_ready  (rsp_ready),
  .evicted    (evicted),
  .evicted_id (evicted_id),
  .present    (present),
  .occupancy  (occupancy)
);

`default_nettype wire

FILE: sim/tb_lru_recency_tracker_unit.sv
// Self-checking testbench for lru_recency_tracker_unit: request driver, result monitor and
// a request-level recency-order predictor, with capacity changes over the APB port.
// Depends on lrt_pkg and the RTL of the tracker.
`default_nettype none

module tb_lru_recency_tracker_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH       = 16;
  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned POOL_SIZE   = 20;
  localparam logic [1:0]  REQ_NOP     = 2'd3;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] id;
  } lookup_req_t;

  typedef struct packed {
    logic       evicted;
    logic [7:0] evicted_id;
    logic       present;
    logic [4:0] occupancy;
  } lookup_rsp_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           req_valid = 1'b0;
  logic                           req_ready;
  logic [1:0]                     req_type = 2'd0;
  logic [lrt_pkg::FIELD_ID_W-1:0] entry_id = '0;
  logic                           rsp_valid;
  logic                           rsp_ready = 1'b0;
  logic                           evicted;
  logic [lrt_pkg::FIELD_ID_W-1:0] evicted_id;
  logic                           present;
  logic [lrt_pkg::OCC_BITS-1:0]   occupancy;
  logic                           psel = 1'b0;
  logic                           penable = 1'b0;
  logic                           pwrite = 1'b0;
  logic [lrt_pkg::ADDR_W-1:0]     paddr = '0;
  logic [lrt_pkg::DATA_W-1:0]     pwdata = '0;
  logic [lrt_pkg::DATA_W-1:0]     prdata;
  logic                           pready;

  lru_recency_tracker_unit dut (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req_type   (req_type),
    .entry_id   (entry_id),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready),
    .evicted    (evicted),
    .evicted_id (evicted_id),
    .present    (present),
    .occupancy  (occupancy),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  lookup_req_t request_q[$];
  lookup_rsp_t expected_rsp_q[$];

  logic [7:0]  mru_order [DEPTH];
  int unsigned held_total = 0;
  logic [4:0]  capacity_setting = lrt_pkg::CAPACITY_RESET;

  int unsigned items_queued   = 0;
  int unsigned items_accepted = 0;
  int unsigned results_seen   = 0;
  int unsigned evictions_seen = 0;
  int unsigned hits_seen      = 0;
  int unsigned settings_used  = 1;
  int unsigned error_count    = 0;
  int unsigned cycle_count    = 0;

  int unsigned send_wait = 0;
  int unsigned recv_wait = 0;
  logic        send_burst = 1'b0;
  logic        recv_burst = 1'b0;
  lookup_req_t next_req;
  lookup_rsp_t got_rsp;
  lookup_rsp_t want_rsp;

  // Updates the predicted recency order for one request and returns the expected result.
  function automatic lookup_rsp_t apply_request(input logic [1:0] kind, input logic [7:0] id);
    lookup_rsp_t rsp;
    int unsigned pos;
    int unsigned limit;
    int unsigned i;
    logic        found;
    rsp   = '0;
    found = 1'b0;
    pos   = held_total;
    for (i = 0; i < held_total; i++) begin
      if (!found && mru_order[i] == id) begin
        found = 1'b1;
        pos   = i;
      end
    end
    limit = 32'(capacity_setting);
    if (limit < 1) limit = 1;
    if (limit > DEPTH) limit = DEPTH;
    if (found && (kind == lrt_pkg::REQ_INSERT || kind == lrt_pkg::REQ_TOUCH)) begin
      for (i = pos; i > 0; i--) mru_order[i] = mru_order[i-1];
      mru_order[0] = id;
    end else if (!found && kind == lrt_pkg::REQ_INSERT) begin
      if (held_total >= limit && held_total > 0) begin
        rsp.evicted    = 1'b1;
        rsp.evicted_id = mru_order[held_total-1];
        held_total--;
      end
      for (i = held_total; i > 0; i--) mru_order[i] = mru_order[i-1];
      mru_order[0] = id;
      held_total++;
    end else if (found && kind == lrt_pkg::REQ_REMOVE) begin
      for (i = pos; i + 1 < held_total; i++) mru_order[i] = mru_order[i+1];
      held_total--;
    end
    rsp.present   = found;
    rsp.occupancy = held_total[4:0];
    return rsp;
  endfunction

  function automatic int unsigned draw_wait(inout logic burst);
    if ($urandom_range(0, 99) < 4) burst = !burst;
    return burst ? 0 : $urandom_range(0, 6);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      send_wait = 0;
    end else begin
      if (req_valid && req_ready) begin
        expected_rsp_q.push_back(apply_request(req_type, entry_id));
        items_accepted++;
        send_wait = draw_wait(send_burst);
      end
      if (req_valid && !req_ready) begin
        // Hold the current transaction until it is taken.
      end else if (send_wait > 0) begin
        send_wait--;
        req_valid <= 1'b0;
      end else if (request_q.size() > 0) begin
        next_req = request_q.pop_front();
        req_valid <= 1'b1;
        req_type  <= next_req.kind;
        entry_id  <= next_req.id;
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
      recv_wait = 0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        got_rsp = '{evicted, evicted_id, present, occupancy};
        results_seen++;
        if (expected_rsp_q.size() == 0) begin
          error_count++;
          if (error_count <= 10)
            $display("Unexpected result at cycle %0d: evicted=%0b id=%0d present=%0b occ=%0d",
                     cycle_count, got_rsp.evicted, got_rsp.evicted_id, got_rsp.present,
                     got_rsp.occupancy);
        end else begin
          want_rsp = expected_rsp_q.pop_front();
          if (got_rsp !== want_rsp) begin
            error_count++;
            if (error_count <= 10) begin
              $display("Mismatch on result %0d: expected evicted=%0b id=%0d present=%0b occ=%0d",
                       results_seen, want_rsp.evicted, want_rsp.evicted_id, want_rsp.present,
                       want_rsp.occupancy);
              $display("  got evicted=%0b id=%0d present=%0b occ=%0d",
                       got_rsp.evicted, got_rsp.evicted_id, got_rsp.present,
                       got_rsp.occupancy);
            end
          end
          if (want_rsp.evicted) evictions_seen++;
          if (want_rsp.present) hits_seen++;
        end
        recv_wait = draw_wait(recv_burst);
      end
      if (recv_wait > 0) begin
        recv_wait--;
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycle_count,
               expected_rsp_q.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic queue_request(input logic [1:0] kind, input logic [7:0] id);
    request_q.push_back('{kind, id});
    items_queued++;
  endtask

  task automatic wait_until_idle();
    while (items_accepted != items_queued || expected_rsp_q.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [4:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= lrt_pkg::REG_CAPACITY;
    pwdata  <= {{(lrt_pkg::DATA_W-5){1'b0}}, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    capacity_setting = value;
    settings_used++;
  endtask

  task automatic run_random_phase(input int unsigned count);
    logic [7:0]  pool [POOL_SIZE];
    logic [1:0]  kind;
    logic [7:0]  id;
    int unsigned roll;
    int unsigned n;
    for (n = 0; n < POOL_SIZE; n++) pool[n] = 8'($urandom_range(0, 255));
    for (n = 0; n < count; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < 45) kind = lrt_pkg::REQ_INSERT;
      else if (roll < 70) kind = lrt_pkg::REQ_TOUCH;
      else if (roll < 92) kind = lrt_pkg::REQ_REMOVE;
      else kind = REQ_NOP;
      if ($urandom_range(0, 9) < 7) id = pool[$urandom_range(0, POOL_SIZE-1)];
      else id = 8'($urandom_range(0, 255));
      queue_request(kind, id);
      if (n == count / 2) wait_until_idle();
    end
    wait_until_idle();
  endtask

  initial begin
    logic [4:0] phase_caps [10];
    int unsigned p;
    phase_caps = '{5'd16, 5'd3, 5'd1, 5'd0, 5'd31, 5'd17, 5'd2, 5'd9, 5'd16, 5'd6};
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    queue_request(lrt_pkg::REQ_REMOVE, 8'd5);
    queue_request(lrt_pkg::REQ_TOUCH, 8'd7);
    queue_request(REQ_NOP, 8'd9);
    queue_request(lrt_pkg::REQ_INSERT, 8'h00);
    queue_request(lrt_pkg::REQ_INSERT, 8'hFF);
    queue_request(lrt_pkg::REQ_INSERT, 8'hAA);
    queue_request(lrt_pkg::REQ_INSERT, 8'h55);
    queue_request(lrt_pkg::REQ_INSERT, 8'hFF);
    queue_request(lrt_pkg::REQ_TOUCH, 8'h00);
    queue_request(lrt_pkg::REQ_TOUCH, 8'h03);
    queue_request(lrt_pkg::REQ_REMOVE, 8'hAA);
    queue_request(lrt_pkg::REQ_REMOVE, 8'hAA);
    queue_request(REQ_NOP, 8'hFF);
    queue_request(lrt_pkg::REQ_INSERT, 8'h80);
    wait_until_idle();

    // Capacity drops below the held count: each new insert evicts exactly one id.
    write_capacity(5'd1);
    queue_request(lrt_pkg::REQ_INSERT, 8'h01);
    queue_request(lrt_pkg::REQ_INSERT, 8'h7F);
    queue_request(lrt_pkg::REQ_INSERT, 8'h7F);
    queue_request(lrt_pkg::REQ_TOUCH, 8'hFF);
    queue_request(lrt_pkg::REQ_REMOVE, 8'h7F);
    queue_request(lrt_pkg::REQ_REMOVE, 8'h00);
    queue_request(lrt_pkg::REQ_REMOVE, 8'hFF);
    queue_request(lrt_pkg::REQ_REMOVE, 8'h01);
    queue_request(lrt_pkg::REQ_INSERT, 8'h42);
    wait_until_idle();

    for (p = 0; p < 10; p++) begin
      write_capacity(phase_caps[p]);
      run_random_phase(113);
    end

    if (expected_rsp_q.size() > 0) error_count += expected_rsp_q.size();
    $display("Checked %0d results from %0d requests across %0d capacity settings.",
             results_seen, items_accepted, settings_used);
    $display("Predicted %0d evictions and %0d requests on ids already held.",
             evictions_seen, hits_seen);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire
